FILE: rtl/core/assert_macros.svh
// Assertion helpers used by scfw_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under active-low reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under active-low reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/scfw_pkg.sv
package scfw_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam int CMD_W    = 2;
    localparam int SECTOR_W = 32;
    localparam int DISK_W   = 8;
    localparam int OWNER_W  = 8;
    localparam int KIND_W   = 3;
    localparam int SLOT_W   = 4;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_PAD_W  = OUT_DATA_W - SLOT_W - SECTOR_W - DISK_W;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FILL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_HIT     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MISS    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WB      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PLACED  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FLUSHED = 3'd4;

    typedef struct packed {
        logic                lookup;
        logic                flush;
        logic                wr;
        logic [SECTOR_W-1:0] sector;
        logic [DISK_W-1:0]   disk;
        logic [OWNER_W-1:0]  owner;
    } t_req;

endpackage

FILE: rtl/core/scfw_front.sv
module scfw_front
    import scfw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [IN_DATA_W-1:0] i_s_tdata,
    input  logic [CMD_W-1:0]     i_s_tuser,
    output logic                 o_req_valid,
    output t_req                 o_req,
    input  logic                 i_req_ready
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_req           r_q [QUEUE_DEPTH];
    logic [QW-1:0]  r_wr_ptr;
    logic [QW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    t_req           w_req;
    logic           w_push;
    logic           w_pop;

    always_comb begin
        w_req        = '0;
        w_req.sector = i_s_tdata[SECTOR_W-1:0];
        w_req.disk   = i_s_tdata[SECTOR_W+DISK_W-1:SECTOR_W];
        w_req.owner  = i_s_tdata[SECTOR_W+DISK_W+OWNER_W-1:SECTOR_W+DISK_W];
        case (i_s_tuser)
            CMD_LOOKUP: w_req.lookup = 1'b1;
            CMD_FILL:   w_req.wr     = 1'b0;
            CMD_WRITE:  w_req.wr     = 1'b1;
            CMD_FLUSH:  w_req.flush  = 1'b1;
            default:    w_req.lookup = 1'b0;
        endcase
    end

    assign o_s_tready  = (r_count != CW'(QUEUE_DEPTH));
    assign o_req_valid = (r_count != '0);
    assign o_req       = r_q[r_rd_ptr];
    assign w_push      = i_s_tvalid && o_s_tready;
    assign w_pop       = o_req_valid && i_req_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/core/scfw_engine.sv
module scfw_engine
    import scfw_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  t_req                i_req,
    output logic                o_req_ready,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [KIND_W-1:0]   o_kind,
    output logic [SLOT_W-1:0]   o_slot,
    output logic [SECTOR_W-1:0] o_wb_sector,
    output logic [DISK_W-1:0]   o_wb_disk,
    output logic                o_last
);

    localparam int IW = $clog2(ENTRIES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    t_req                r_req;
    logic [ENTRIES-1:0]  r_valid;
    logic [ENTRIES-1:0]  r_dirty;
    logic [SECTOR_W-1:0] r_sector [ENTRIES];
    logic [DISK_W-1:0]   r_disk   [ENTRIES];
    logic [OWNER_W-1:0]  r_owner  [ENTRIES];
    logic [IW-1:0]       r_victim;
    logic [ENTRIES-1:0]  r_match;
    logic [ENTRIES-1:0]  r_sel_oh;
    logic [ENTRIES-1:0]  r_pend;
    logic                r_found;
    logic                r_wb;
    logic [IW-1:0]       r_sel;

    logic                r_ov;
    logic [KIND_W-1:0]   r_okind;
    logic [SLOT_W-1:0]   r_oslot;
    logic [SECTOR_W-1:0] r_osec;
    logic [DISK_W-1:0]   r_odisk;
    logic                r_olast;

    logic [ENTRIES-1:0]  w_match;
    logic [ENTRIES-1:0]  w_own_ne;
    logic [ENTRIES-1:0]  w_first_oh;
    logic [IW-1:0]       w_first_idx;
    logic                w_found;
    logic                w_wb_need;
    logic [IW-1:0]       w_pend_idx;
    logic                w_pend_any;
    logic [IW-1:0]       w_rd_idx;
    logic                w_run;
    logic                w_done;
    logic                w_commit;
    logic                w_clean;
    logic [IW-1:0]       w_clean_idx;
    logic                w_pop;
    logic [KIND_W-1:0]   w_kind;
    logic [IW-1:0]       w_slot;
    logic                w_wb_out;

    always_comb begin
        w_first_oh  = '0;
        w_first_idx = '0;
        w_pend_idx  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i]  = r_valid[i] && (r_sector[i] == r_req.sector)
                          && (r_disk[i] == r_req.disk);
            w_own_ne[i] = (r_owner[i] != r_req.owner);
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_first_idx   = IW'(i);
                w_first_oh    = '0;
                w_first_oh[i] = 1'b1;
            end
            if (r_pend[i]) begin
                w_pend_idx = IW'(i);
            end
        end
        w_found    = |w_match;
        w_pend_any = |r_pend;
        w_wb_need  = w_found ? |(w_first_oh & r_dirty & w_own_ne)
                             : (r_valid[r_victim] && r_dirty[r_victim]);
    end

    assign w_rd_idx = r_req.flush ? w_pend_idx : r_sel;
    assign w_run    = (r_state == S_RUN) && (!r_ov || i_m_tready);

    always_comb begin
        w_kind      = KIND_PLACED;
        w_slot      = r_sel;
        w_wb_out    = 1'b0;
        w_done      = 1'b0;
        w_commit    = 1'b0;
        w_clean     = 1'b0;
        w_clean_idx = r_sel;
        if (r_req.lookup) begin
            w_kind = r_found ? KIND_HIT : KIND_MISS;
            w_slot = r_found ? r_sel : '0;
            w_done = 1'b1;
        end else if (r_req.flush) begin
            if (w_pend_any) begin
                w_kind      = KIND_WB;
                w_slot      = w_pend_idx;
                w_wb_out    = 1'b1;
                w_clean     = 1'b1;
                w_clean_idx = w_pend_idx;
            end else begin
                w_kind = KIND_FLUSHED;
                w_slot = '0;
                w_done = 1'b1;
            end
        end else if (r_wb) begin
            w_kind   = KIND_WB;
            w_wb_out = 1'b1;
            w_clean  = 1'b1;
        end else begin
            w_done   = 1'b1;
            w_commit = w_run;
        end
    end

    assign o_req_ready = (r_state == S_IDLE) || (w_run && w_done);
    assign w_pop       = i_req_valid && o_req_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_pop) n_state = S_CMP;
            S_CMP:   n_state = S_RUN;
            S_RUN:   if (w_run && w_done) n_state = w_pop ? S_CMP : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_req <= i_req;
        end
        if (r_state == S_CMP) begin
            r_match  <= w_match;
            r_sel_oh <= w_first_oh;
            r_found  <= w_found;
            r_sel    <= w_found ? w_first_idx : r_victim;
        end
        if (w_commit) begin
            r_owner[r_sel] <= r_req.owner;
            if (!r_found) begin
                r_sector[r_sel] <= r_req.sector;
                r_disk[r_sel]   <= r_req.disk;
            end
        end
        if (w_run) begin
            r_okind <= w_kind;
            r_oslot <= SLOT_W'(w_slot);
            r_osec  <= w_wb_out ? r_sector[w_rd_idx] : '0;
            r_odisk <= w_wb_out ? r_disk[w_rd_idx] : '0;
            r_olast <= !w_wb_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_dirty  <= '0;
            r_victim <= '0;
            r_pend   <= '0;
            r_wb     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CMP) begin
                r_pend <= r_valid & r_dirty & ~w_own_ne;
                r_wb   <= w_wb_need;
            end
            if (w_run && w_clean) begin
                r_dirty[w_clean_idx] <= 1'b0;
                r_pend[w_clean_idx]  <= 1'b0;
                r_wb                 <= 1'b0;
            end
            if (w_commit) begin
                if (r_found) begin
                    r_valid        <= r_valid & ~(r_match & ~r_sel_oh);
                    r_dirty[r_sel] <= r_dirty[r_sel] | r_req.wr;
                end else begin
                    r_valid[r_sel] <= 1'b1;
                    r_dirty[r_sel] <= r_req.wr;
                    r_victim       <= (r_victim == IW'(ENTRIES - 1)) ? '0 : r_victim + 1'b1;
                end
            end
            if (w_run) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_m_tvalid  = r_ov;
    assign o_kind      = r_okind;
    assign o_slot      = r_oslot;
    assign o_wb_sector = r_osec;
    assign o_wb_disk   = r_odisk;
    assign o_last      = r_olast;

endmodule

FILE: rtl/core/sector_cache_fifo_writeback.sv
// Tag and policy controller of a fully associative write-back sector cache
// with round-robin replacement.
// Slave stream: one request per command; tuser carries the command, tdata
// the sector, disk and owner. Master stream: the results of each command,
// zero or more write-back requests followed by one result with tlast set.
// A request enters a two-deep queue; the back end pops it into a request
// register, compares all tags in parallel into the compare registers and
// emits one result per cycle from an output register while tready is high.
// A lookup, fill or write has a compare step, a write-back when needed
// and a result; a flush writes back each dirty entry of its owner first.
// Reset clears all valid and dirty bits, the victim pointer and the queue.
// When the receiver holds tready low the output register keeps its result
// and the back end stalls; the queue keeps taking requests until full.
module sector_cache_fifo_writeback
    import scfw_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // sector[31:0], disk_id[39:32], owner_id[47:40]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // command[1:0]
    input  logic [CMD_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // slot[3:0], wb_sector[35:4], wb_disk[43:36], zero[47:44]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // result_kind[2:0]
    output logic [KIND_W-1:0]     m_axis_tuser,
    output logic                  m_axis_tlast
);

    logic                w_req_valid;
    logic                w_req_ready;
    t_req                w_req;
    logic [SLOT_W-1:0]   w_slot;
    logic [SECTOR_W-1:0] w_wb_sector;
    logic [DISK_W-1:0]   w_wb_disk;

    scfw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .o_req_valid (w_req_valid),
        .o_req       (w_req),
        .i_req_ready (w_req_ready)
    );

    scfw_engine #(
        .ENTRIES (ENTRIES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_req_valid),
        .i_req       (w_req),
        .o_req_ready (w_req_ready),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_kind      (m_axis_tuser),
        .o_slot      (w_slot),
        .o_wb_sector (w_wb_sector),
        .o_wb_disk   (w_wb_disk),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, w_wb_disk, w_wb_sector, w_slot};

endmodule

FILE: rtl/core/scfw_checker.sv
`include "assert_macros.svh"

module scfw_checker
    import scfw_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] i_m_tdata,
    input logic [KIND_W-1:0]     i_m_tuser,
    input logic                  i_m_tlast
);

    `ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser) && $stable(i_m_tlast))
    `ASSERT_IMPL(a_kind_range, i_clk, i_rst_n, i_m_tvalid, i_m_tuser <= KIND_FLUSHED)
    `ASSERT_IMPL(a_last_rule, i_clk, i_rst_n, i_m_tvalid, i_m_tlast == (i_m_tuser != KIND_WB))
    `ASSERT_IMPL(a_unused_zero, i_clk, i_rst_n, i_m_tvalid && (i_m_tuser != KIND_WB), i_m_tdata[OUT_DATA_W-1:SLOT_W] == '0)

endmodule

bind sector_cache_fifo_writeback scfw_checker u_scfw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser),
    .i_m_tlast  (m_axis_tlast)
);

FILE: verif/scfw_checker.sv
`timescale 1ns / 1ps

module scfw_scoreboard
    import scfw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    // sector[31:0], disk_id[39:32], owner_id[47:40]
    input  logic [IN_DATA_W-1:0]  i_req_data,
    // command[1:0]
    input  logic [CMD_W-1:0]      i_req_cmd,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    // slot[3:0], wb_sector[35:4], wb_disk[43:36], zero[47:44]
    input  logic [OUT_DATA_W-1:0] i_res_data,
    // result_kind[2:0]
    input  logic [KIND_W-1:0]     i_res_kind,
    input  logic                  i_res_last,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [SLOT_W-1:0]   slot;
        logic [SECTOR_W-1:0] wb_sector;
        logic [DISK_W-1:0]   wb_disk;
        logic                last;
    } t_result;

    logic                line_valid  [ENTRIES_DEF];
    logic                line_dirty  [ENTRIES_DEF];
    logic [OWNER_W-1:0]  line_owner  [ENTRIES_DEF];
    logic [DISK_W-1:0]   line_disk   [ENTRIES_DEF];
    logic [SECTOR_W-1:0] line_sector [ENTRIES_DEF];
    logic [SLOT_W-1:0]   victim_slot;

    t_result awaited_results[$];
    int      mismatch_total = 0;
    int      awaited_total  = 0;

    assign o_fail_count = mismatch_total;
    assign o_pending    = awaited_total;

    task automatic report_mismatch(input string what);
        mismatch_total++;
        $display("%0t scfw_scoreboard: %s", $time, what);
    endtask

    task automatic push_result(input logic [KIND_W-1:0] kind, input int slot,
                               input logic [SECTOR_W-1:0] sector,
                               input logic [DISK_W-1:0] disk, input logic last);
        t_result r;
        r.kind      = kind;
        r.slot      = slot[SLOT_W-1:0];
        r.wb_sector = sector;
        r.wb_disk   = disk;
        r.last      = last;
        awaited_results.push_back(r);
    endtask

    task automatic write_back_line(input int i);
        if (line_valid[i] && line_dirty[i]) begin
            push_result(KIND_WB, i, line_sector[i], line_disk[i], 1'b0);
            line_dirty[i] = 1'b0;
        end
    endtask

    task automatic apply_command(input logic [CMD_W-1:0] cmd,
                                 input logic [SECTOR_W-1:0] sector,
                                 input logic [DISK_W-1:0] disk,
                                 input logic [OWNER_W-1:0] owner);
        logic found;
        int   placed;
        found  = 1'b0;
        placed = 0;
        if (cmd == CMD_LOOKUP) begin
            for (int i = 0; i < ENTRIES_DEF; i++) begin
                if (!found && line_valid[i] && line_sector[i] == sector
                        && line_disk[i] == disk) begin
                    found  = 1'b1;
                    placed = i;
                end
            end
            if (found) begin
                push_result(KIND_HIT, placed, '0, '0, 1'b1);
            end else begin
                push_result(KIND_MISS, 0, '0, '0, 1'b1);
            end
        end else if (cmd == CMD_FLUSH) begin
            for (int i = 0; i < ENTRIES_DEF; i++) begin
                if (line_valid[i] && line_owner[i] == owner) begin
                    write_back_line(i);
                end
            end
            push_result(KIND_FLUSHED, 0, '0, '0, 1'b1);
        end else begin
            for (int i = 0; i < ENTRIES_DEF; i++) begin
                if (line_valid[i] && line_sector[i] == sector && line_disk[i] == disk) begin
                    if (found) begin
                        line_valid[i] = 1'b0;
                    end else begin
                        if (line_owner[i] != owner) begin
                            write_back_line(i);
                            line_owner[i] = owner;
                        end
                        if (cmd == CMD_WRITE) begin
                            line_dirty[i] = 1'b1;
                        end
                        found  = 1'b1;
                        placed = i;
                    end
                end
            end
            if (!found) begin
                placed = victim_slot;
                write_back_line(placed);
                line_sector[placed] = sector;
                line_disk[placed]   = disk;
                line_valid[placed]  = 1'b1;
                line_dirty[placed]  = (cmd == CMD_WRITE);
                line_owner[placed]  = owner;
                victim_slot         = victim_slot + 1'b1;
            end
            push_result(KIND_PLACED, placed, '0, '0, 1'b1);
        end
    endtask

    task automatic compare_result();
        t_result want;
        if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("result with no request outstanding: kind %0d data %h last %b",
                                      i_res_kind, i_res_data, i_res_last));
        end else begin
            want = awaited_results.pop_front();
            if (i_res_kind !== want.kind || i_res_data[3:0] !== want.slot
                    || i_res_data[35:4] !== want.wb_sector
                    || i_res_data[43:36] !== want.wb_disk
                    || i_res_data[47:44] !== '0 || i_res_last !== want.last) begin
                report_mismatch($sformatf(
                    "got kind %0d slot %0d sec %h disk %h pad %h last %b, want %0d %0d %h %h 0 %b",
                    i_res_kind, i_res_data[3:0], i_res_data[35:4], i_res_data[43:36],
                    i_res_data[47:44], i_res_last, want.kind, want.slot, want.wb_sector,
                    want.wb_disk, want.last));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES_DEF; i++) begin
                line_valid[i] = 1'b0;
                line_dirty[i] = 1'b0;
            end
            victim_slot = '0;
            awaited_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                compare_result();
            end
            if (i_req_valid && i_req_ready) begin
                apply_command(i_req_cmd, i_req_data[31:0], i_req_data[39:32],
                              i_req_data[47:40]);
            end
        end
        awaited_total = awaited_results.size();
    end

endmodule

FILE: verif/tb_sector_cache_fifo_writeback.sv
`timescale 1ns / 1ps

module tb_sector_cache_fifo_writeback;
    import scfw_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // sector[31:0], disk_id[39:32], owner_id[47:40]
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // command[1:0]
    logic [CMD_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // slot[3:0], wb_sector[35:4], wb_disk[43:36], zero[47:44]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // result_kind[2:0]
    logic [KIND_W-1:0]     m_axis_tuser;
    logic                  m_axis_tlast;

    int fail_count;
    int pending;
    int stuck_cycles = 0;
    int ready_hold   = 0;
    logic quiet_phase = 1'b0;

    logic [SECTOR_W-1:0] sector_pool [24];
    logic [DISK_W-1:0]   disk_pool   [4];
    logic [OWNER_W-1:0]  owner_pool  [4];

    sector_cache_fifo_writeback dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    scfw_scoreboard cache_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_cmd    (s_axis_tuser),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_kind   (m_axis_tuser),
        .i_res_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // hold tready low for random stretches
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            m_axis_tready <= 1'b0;
            ready_hold    <= ready_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                ready_hold <= idle_len();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STALL_LIMIT) begin
                $display("** sector_cache_fifo_writeback: FAILED **");
                $finish;
            end
        end
    end

    task automatic issue_request(input logic [CMD_W-1:0] cmd,
                                 input logic [SECTOR_W-1:0] sector,
                                 input logic [DISK_W-1:0] disk,
                                 input logic [OWNER_W-1:0] owner);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {owner, disk, sector};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        int                  pick;
        logic [CMD_W-1:0]    cmd;
        logic [SECTOR_W-1:0] sector;
        logic [DISK_W-1:0]   disk;
        logic [OWNER_W-1:0]  owner;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_LOOKUP;
        for (int k = 0; k < 24; k++) begin
            sector_pool[k] = $urandom;
        end
        sector_pool[0] = '0;
        sector_pool[1] = '1;
        disk_pool  = '{8'h00, 8'hFF, 8'h00, 8'h00};
        disk_pool[2] = 8'($urandom_range(1, 254));
        disk_pool[3] = 8'($urandom_range(1, 254));
        owner_pool = '{8'h00, 8'h01, 8'h80, 8'hFF};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        issue_request(CMD_LOOKUP, 32'h0000_0000, 8'h00, 8'h00);
        issue_request(CMD_FILL,   32'h0000_0000, 8'h00, 8'h00);
        issue_request(CMD_LOOKUP, 32'h0000_0000, 8'h00, 8'h00);
        issue_request(CMD_WRITE,  32'hFFFF_FFFF, 8'hFF, 8'hFF);
        issue_request(CMD_LOOKUP, 32'hFFFF_FFFF, 8'hFF, 8'h00);
        issue_request(CMD_LOOKUP, 32'hFFFF_FFFF, 8'h00, 8'h00);
        // read fill over a dirty line keeps it dirty
        issue_request(CMD_FILL,   32'hFFFF_FFFF, 8'hFF, 8'hFF);
        // owner change on a dirty line forces a write-back
        issue_request(CMD_WRITE,  32'hFFFF_FFFF, 8'hFF, 8'h01);
        issue_request(CMD_FLUSH,  32'h0000_0000, 8'h00, 8'h55);
        issue_request(CMD_WRITE,  32'h0000_0000, 8'h00, 8'h00);
        // wrap the victim pointer and evict the dirty line at slot 0
        for (int k = 0; k < 15; k++) begin
            issue_request(CMD_WRITE, 32'hA5A5_0000 + k, k[7:0], 8'h07);
        end
        issue_request(CMD_FLUSH, 32'hFFFF_FFFF, 8'hFF, 8'h07);

        for (int k = 0; k < 480; k++) begin
            if (k % 40 == 0) begin
                quiet_phase = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                cmd = CMD_LOOKUP;
            end else if (pick < 55) begin
                cmd = CMD_FILL;
            end else if (pick < 90) begin
                cmd = CMD_WRITE;
            end else begin
                cmd = CMD_FLUSH;
            end
            if ($urandom_range(0, 9) == 0) begin
                sector = $urandom;
                disk   = 8'($urandom_range(0, 255));
                owner  = 8'($urandom_range(0, 255));
            end else begin
                sector = sector_pool[$urandom_range(0, 23)];
                disk   = disk_pool[$urandom_range(0, 1)];
                owner  = owner_pool[$urandom_range(0, 3)];
                if ($urandom_range(0, 7) == 0) begin
                    disk = disk_pool[$urandom_range(2, 3)];
                end
            end
            issue_request(cmd, sector, disk, owner);
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** sector_cache_fifo_writeback: PASSED **");
        end else begin
            $display("** sector_cache_fifo_writeback: FAILED **");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/scfw_pkg.sv
rtl/core/scfw_front.sv
rtl/core/scfw_engine.sv
rtl/core/sector_cache_fifo_writeback.sv
rtl/core/scfw_checker.sv
verif/scfw_checker.sv
verif/tb_sector_cache_fifo_writeback.sv
